// ----- src/rwmg_pkg.sv -----
`timescale 1ns / 1ps
package rwmg_pkg;
  localparam int MaxWidth = 32;
  localparam int LabelBits = 6;
  localparam int LabelCount = 1 << LabelBits;
  localparam int ColBits = $clog2(MaxWidth);
  localparam int WidthBits = 6;

  typedef logic [LabelBits-1:0] label_t;
  typedef logic [ColBits-1:0] col_t;

  typedef enum logic [3:0] {
    StIdle,
    StMerge,
    StRelabel,
    StDown,
    StUsed,
    StFresh,
    StDone
  } state_e;

  typedef struct packed {
    logic load;
    logic merge_step;
    logic relabel_step;
    logic down_step;
    logic used_step;
    logic fresh_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic merge_hit;
    logic merge_end;
    logic relabel_end;
    logic down_end;
    logic used_end;
    logic fresh_end;
    logic last;
  } sts_t;
endpackage

// ----- src/row_wise_maze_generator_core.sv -----
`timescale 1ns / 1ps
// each right merge adds a relabel pass over the used width, one cell a cycle, and the
// fresh-label search steps once for each used label that it skips;
// the fresh pass always walks all 32 columns
// throughput: one row at a time, next request taken the cycle after the result is registered
// reset: labels return to column index, width to 32, output valid cleared
module row_wise_maze_generator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,  // right_bits[30:0], down_bits[62:31]
  input  logic [1:0]  s_axis_tuser_i,  // first_row, last_row
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,  // right_open[30:0], down_open[62:31]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [rwmg_pkg::WidthBits-1:0] row_width_q;
  rwmg_pkg::cmd_t cmd;
  rwmg_pkg::sts_t sts;
  logic [30:0] right_open;
  logic [31:0] down_open;

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) row_width_q <= rwmg_pkg::WidthBits'(32);
    else if (psel && penable && pwrite && paddr == 2'd0)
      row_width_q <= pwdata[rwmg_pkg::WidthBits-1:0];
  end
  assign prdata = (paddr == 2'd0) ? 32'(row_width_q) : '0;

  rwmg_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(s_axis_tvalid_i), .in_ready_o(s_axis_tready_o),
    .out_valid_o(m_axis_tvalid_o), .out_ready_i(m_axis_tready_i),
    .sts_i(sts), .cmd_o(cmd)
  );

  rwmg_dp u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .row_width_i(row_width_q),
    .first_row_i(s_axis_tuser_i[0]), .last_row_i(s_axis_tuser_i[1]),
    .right_bits_i(s_axis_tdata_i[30:0]), .down_bits_i(s_axis_tdata_i[62:31]),
    .cmd_i(cmd), .sts_o(sts),
    .right_open_o(right_open), .down_open_o(down_open)
  );

  assign m_axis_tdata_o = {1'b0, down_open, right_open};
endmodule

// ----- src/rwmg_ctrl.sv -----
`timescale 1ns / 1ps
module rwmg_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  rwmg_pkg::sts_t   sts_i,
  output rwmg_pkg::cmd_t   cmd_o
);
  rwmg_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rwmg_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rwmg_pkg::StIdle: if (in_valid_i) state_d = rwmg_pkg::StMerge;
      rwmg_pkg::StMerge: begin
        if (sts_i.merge_hit) state_d = rwmg_pkg::StRelabel;
        else if (sts_i.merge_end) state_d = sts_i.last ? rwmg_pkg::StUsed : rwmg_pkg::StDown;
      end
      rwmg_pkg::StRelabel: if (sts_i.relabel_end) begin
        if (sts_i.merge_end) state_d = sts_i.last ? rwmg_pkg::StUsed : rwmg_pkg::StDown;
        else state_d = rwmg_pkg::StMerge;
      end
      rwmg_pkg::StDown: if (sts_i.down_end) state_d = rwmg_pkg::StUsed;
      rwmg_pkg::StUsed: if (sts_i.used_end) state_d = rwmg_pkg::StFresh;
      rwmg_pkg::StFresh: if (sts_i.fresh_end) state_d = rwmg_pkg::StDone;
      rwmg_pkg::StDone: if (!out_valid_q || out_ready_i) state_d = rwmg_pkg::StIdle;
      default: state_d = rwmg_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      rwmg_pkg::StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      rwmg_pkg::StMerge: cmd_o.merge_step = 1'b1;
      rwmg_pkg::StRelabel: cmd_o.relabel_step = 1'b1;
      rwmg_pkg::StDown: cmd_o.down_step = 1'b1;
      rwmg_pkg::StUsed: cmd_o.used_step = 1'b1;
      rwmg_pkg::StFresh: cmd_o.fresh_step = 1'b1;
      rwmg_pkg::StDone: if (!out_valid_q || out_ready_i) begin
        cmd_o.out_load = 1'b1;
        out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
endmodule

// ----- src/rwmg_dp.sv -----
`timescale 1ns / 1ps
module rwmg_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [rwmg_pkg::WidthBits-1:0] row_width_i,
  input  logic                          first_row_i,
  input  logic                          last_row_i,
  input  logic [30:0]                   right_bits_i,
  input  logic [31:0]                   down_bits_i,
  input  rwmg_pkg::cmd_t                cmd_i,
  output rwmg_pkg::sts_t                sts_o,
  output logic [30:0]                   right_open_o,
  output logic [31:0]                   down_open_o
);
  localparam int MW = rwmg_pkg::MaxWidth;
  localparam int CB = rwmg_pkg::ColBits;

  rwmg_pkg::label_t row_q [MW];
  rwmg_pkg::label_t above_q [MW];
  logic first_q, last_q;
  logic [30:0] rbits_q, right_q, right_out_q;
  logic [MW-1:0] dbits_q, down_q, down_out_q;
  logic [CB:0] wid_q;       // used width, 1..MaxWidth
  logic [CB:0] col_q;       // scan column
  logic [CB:0] k_q;         // relabel / fresh counter
  rwmg_pkg::label_t a_q, b_q;
  logic any_q, skip_q;
  logic [CB:0] start_q;
  logic [rwmg_pkg::LabelCount-1:0] used_q;
  logic [rwmg_pkg::LabelBits:0] v_q;   // fresh search pointer

  logic [CB:0] wid_c;
  always_comb begin
    if (row_width_i == '0) wid_c = (CB+1)'(1);
    else if (32'(row_width_i) > MW) wid_c = (CB+1)'(MW);
    else wid_c = (CB+1)'(row_width_i);
  end

  // merge compare at column col_q vs col_q+1
  logic [CB-1:0] ci, cn;
  rwmg_pkg::label_t la, lb;
  logic do_join;
  assign ci = col_q[CB-1:0];
  assign cn = ci + CB'(1);
  assign la = row_q[ci];
  assign lb = row_q[cn];
  assign do_join = (la != lb) &&
    (last_q || (!first_q && above_q[cn] != lb) || rbits_q[ci]);
  assign sts_o.merge_end = (col_q + (CB+1)'(1) >= wid_q);
  assign sts_o.merge_hit = cmd_i.merge_step && !sts_o.merge_end && do_join;
  assign sts_o.relabel_end = (k_q + (CB+1)'(1) >= wid_q);
  assign sts_o.down_end = (col_q + (CB+1)'(1) >= wid_q);
  assign sts_o.used_end = (k_q + (CB+1)'(1) >= wid_q);
  assign sts_o.last = last_q;

  // fresh step: one cell per cycle unless the label search must step; the search moves a step when the current is used
  logic [CB-1:0] fk;
  assign fk = k_q[CB-1:0];
  logic fresh_need, v_free;
  assign fresh_need = (k_q < wid_q) && !down_q[fk];
  assign v_free = !v_q[rwmg_pkg::LabelBits] && !used_q[v_q[rwmg_pkg::LabelBits-1:0]];
  assign sts_o.fresh_end = (k_q >= (CB+1)'(MW)) ||
    ((k_q + (CB+1)'(1) >= (CB+1)'(MW)) && (!fresh_need || v_free || v_q[rwmg_pkg::LabelBits]));

  // down step
  logic [CB-1:0] dj;
  logic run_end, dset;
  assign dj = col_q[CB-1:0];
  assign run_end = sts_o.down_end || (row_q[dj + CB'(1)] != row_q[dj]);
  assign dset = !skip_q && dbits_q[dj];

  logic [MW-1:0] down_c;
  logic any_c;
  always_comb begin
    down_c = down_q;
    any_c = any_q || dset;
    if (dset) down_c[dj] = 1'b1;
    // a run with no down passage opens its first cell
    if (run_end && !any_c) down_c[start_q[CB-1:0]] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < MW; c++) row_q[c] <= rwmg_pkg::label_t'(c);
      right_out_q <= '0;
      down_out_q <= '0;
    end else begin
      if (cmd_i.load) begin
        first_q <= first_row_i;
        last_q <= last_row_i;
        rbits_q <= right_bits_i;
        dbits_q <= down_bits_i;
        wid_q <= wid_c;
        col_q <= '0;
        right_q <= '0;
        down_q <= '0;
        if (first_row_i)
          for (int c = 0; c < MW; c++) row_q[c] <= rwmg_pkg::label_t'(c);
      end
      if (cmd_i.merge_step) begin
        if (sts_o.merge_hit) begin
          right_q[ci] <= 1'b1;
          a_q <= la;
          b_q <= lb;
          k_q <= '0;
        end else if (sts_o.merge_end) begin
          col_q <= '0;
          any_q <= 1'b0;
          skip_q <= 1'b0;
          start_q <= '0;
          k_q <= '0;
          used_q <= '0;
        end else col_q <= col_q + (CB+1)'(1);
      end
      if (cmd_i.relabel_step) begin
        if (row_q[k_q[CB-1:0]] == b_q) row_q[k_q[CB-1:0]] <= a_q;
        k_q <= k_q + (CB+1)'(1);
        if (sts_o.relabel_end) begin
          if (sts_o.merge_end) begin
            col_q <= '0;
            any_q <= 1'b0;
            skip_q <= 1'b0;
            start_q <= '0;
            k_q <= '0;
            used_q <= '0;
          end else col_q <= col_q + (CB+1)'(1);
        end
      end
      if (cmd_i.down_step) begin
        if (run_end) begin
          any_q <= 1'b0;
          skip_q <= 1'b0;
          start_q <= col_q + (CB+1)'(1);
        end else begin
          any_q <= any_c;
          skip_q <= dset;
        end
        down_q <= down_c;
        col_q <= col_q + (CB+1)'(1);
      end
      if (cmd_i.used_step) begin
        above_q[fk] <= row_q[fk];
        used_q[row_q[fk]] <= 1'b1;
        k_q <= sts_o.used_end ? '0 : k_q + (CB+1)'(1);
        v_q <= '0;
      end
      if (cmd_i.fresh_step && (k_q < (CB+1)'(MW))) begin
        if (!fresh_need) k_q <= k_q + (CB+1)'(1);
        else if (v_q[rwmg_pkg::LabelBits]) begin
          row_q[fk] <= '1;
          k_q <= k_q + (CB+1)'(1);
        end else if (v_free) begin
          row_q[fk] <= v_q[rwmg_pkg::LabelBits-1:0];
          used_q[v_q[rwmg_pkg::LabelBits-1:0]] <= 1'b1;
          k_q <= k_q + (CB+1)'(1);
        end else v_q <= v_q + (rwmg_pkg::LabelBits+1)'(1);
      end
      if (cmd_i.out_load) begin
        right_out_q <= right_q;
        down_out_q <= last_q ? '0 : down_q;
      end
    end
  end

  assign right_open_o = right_out_q;
  assign down_open_o = down_out_q;
endmodule

// ----- verif/row_wise_maze_generator_core_tb.sv -----
`timescale 1ns / 1ps
module row_wise_maze_generator_core_tb;
  localparam int RowAddr = 0;

  typedef struct packed {
    logic [30:0] right_open;
    logic [31:0] down_open;
  } walls_t;

  class maze_scoreboard;
    rwmg_pkg::label_t  cur_lbl[rwmg_pkg::MaxWidth];
    rwmg_pkg::label_t  prev_lbl[rwmg_pkg::MaxWidth];
    int      width_reg;
    walls_t  pending_walls[$];
    int      mismatches;
    int      rows_checked;

    function new();
      for (int c = 0; c < rwmg_pkg::MaxWidth; c++) begin
        cur_lbl[c] = rwmg_pkg::label_t'(c);
        prev_lbl[c] = '0;
      end
      width_reg = 32;
      mismatches = 0;
      rows_checked = 0;
    endfunction

    function void note_row(logic first, logic last, logic [30:0] rb, logic [31:0] db);
      int w;
      int i;
      int start;
      bit any;
      bit skip;
      bit taken[rwmg_pkg::LabelCount];
      rwmg_pkg::label_t a;
      rwmg_pkg::label_t b;
      rwmg_pkg::label_t fr;
      walls_t res;
      w = width_reg;
      if (w < 1) w = 1;
      if (w > rwmg_pkg::MaxWidth) w = rwmg_pkg::MaxWidth;
      res = '0;
      if (first)
        for (int c = 0; c < rwmg_pkg::MaxWidth; c++) cur_lbl[c] = rwmg_pkg::label_t'(c);
      for (i = 0; i + 1 < w; i++) begin
        a = cur_lbl[i];
        b = cur_lbl[i+1];
        if (a != b && (last || (!first && prev_lbl[i+1] != b) || rb[i])) begin
          res.right_open[i] = 1'b1;
          for (int k = 0; k < w; k++) if (cur_lbl[k] == b) cur_lbl[k] = a;
        end
      end
      if (!last) begin
        i = 0;
        while (i < w) begin
          start = i;
          any = 0;
          skip = 0;
          while (i + 1 < w && cur_lbl[i+1] == cur_lbl[i]) i++;
          for (int j = start; j <= i; j++) begin
            if (skip) skip = 0;
            else if (db[j]) begin
              res.down_open[j] = 1'b1;
              any = 1;
              skip = 1;
            end
          end
          if (!any) res.down_open[start] = 1'b1;
          i++;
        end
      end
      for (int v = 0; v < rwmg_pkg::LabelCount; v++) taken[v] = 0;
      for (int c = 0; c < w; c++) begin
        prev_lbl[c] = cur_lbl[c];
        taken[cur_lbl[c]] = 1;
      end
      for (int c = 0; c < w; c++) begin
        if (!res.down_open[c]) begin
          fr = '1;
          for (int v = 0; v < rwmg_pkg::LabelCount; v++) begin
            if (!taken[v]) begin
              taken[v] = 1;
              fr = rwmg_pkg::label_t'(v);
              break;
            end
          end
          cur_lbl[c] = fr;
        end
      end
      pending_walls.push_back(res);
    endfunction

    function void check_row(logic [63:0] tdata);
      walls_t got;
      walls_t exp;
      got.right_open = tdata[30:0];
      got.down_open = tdata[62:31];
      if (pending_walls.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", tdata);
        return;
      end
      exp = pending_walls.pop_front();
      rows_checked++;
      if (got.right_open !== exp.right_open || got.down_open !== exp.down_open
          || tdata[63] !== 1'b0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("row %0d: right exp %h got %h, down exp %h got %h", rows_checked,
                   exp.right_open, got.right_open, exp.down_open, got.down_open);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i;
  logic [1:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [63:0] m_axis_tdata_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  maze_scoreboard maze_sb;
  bit calm_mode;
  int hold_cycles;
  int rows_sent;

  row_wise_maze_generator_core u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // result side: random stalls, long hold when requested
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) maze_sb.check_row(m_axis_tdata_o);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= calm_mode ? 1'b1 : ($urandom_range(99) >= 12);
      end
    end
  end

  task automatic write_width(int w);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 2'(RowAddr);
    pwdata <= 32'(w);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    maze_sb.width_reg = w & 63;
  endtask

  task automatic send_row(logic first, logic last, logic [30:0] rb, logic [31:0] db);
    while (!calm_mode && $urandom_range(99) < 12) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {1'b0, db, rb};
    s_axis_tuser_i <= {last, first};
    do @(posedge clk_i); while (!s_axis_tready_o);
    maze_sb.note_row(first, last, rb, db);
    rows_sent++;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    s_axis_tvalid_i <= 1'b0;
    while (maze_sb.pending_walls.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (200) @(posedge clk_i);
  endtask

  // a maze of random rows, mostly well formed, occasionally broken by stray first rows
  task automatic random_maze(int rows);
    for (int r = 0; r < rows; r++)
      send_row(r == 0 || $urandom_range(19) == 0, r == rows - 1 && $urandom_range(3) != 0,
               31'($urandom()), $urandom());
  endtask

  initial begin
    maze_sb = new();
    calm_mode = 0;
    hold_cycles = 0;
    rows_sent = 0;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes of the bit fields, first and last together, rows after last
    send_row(1, 0, '0, '0);
    send_row(0, 0, '1, '1);
    send_row(0, 0, 31'h5555_5555, 32'hAAAA_AAAA);
    send_row(0, 1, '0, '1);
    send_row(0, 0, 31'h2AAA_AAAA, 32'h5555_5555);
    send_row(1, 1, '0, '0);
    send_row(0, 0, '0, '0);
    send_row(1, 1, '1, '1);
    drain();
    write_width(1);
    send_row(1, 0, '1, '1);
    send_row(0, 1, '1, '0);
    drain();
    write_width(0);
    send_row(1, 0, '0, '0);
    send_row(0, 0, '1, '1);
    drain();
    write_width(63);
    send_row(1, 0, '0, '0);
    send_row(0, 0, '0, '0);
    drain();
    write_width(2);
    send_row(1, 0, '0, '0);
    send_row(0, 0, '1, '0);
    // width changed mid-maze
    drain();
    write_width(32);
    send_row(0, 0, '0, '0);
    send_row(0, 1, '0, '0);

    // long receiver hold while rows keep coming
    hold_cycles = 600;
    random_maze(6);
    drain();

    calm_mode = 1;
    random_maze(40);
    drain();
    calm_mode = 0;
    while (rows_sent < 440) begin
      write_width($urandom_range(3) == 0 ? 32 : $urandom_range(1, 12));
      random_maze($urandom_range(3, 20));
      drain();
    end

    $display("rows checked: %0d over widths 0 to 63, incl. last rows, width changes and stalls",
             maze_sb.rows_checked);
    if (maze_sb.mismatches == 0 && maze_sb.pending_walls.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("leftover %0d, mismatches %0d", maze_sb.pending_walls.size(), maze_sb.mismatches);
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
src/rwmg_pkg.sv
src/rwmg_ctrl.sv
src/rwmg_dp.sv
src/row_wise_maze_generator_core.sv
verif/row_wise_maze_generator_core_tb.sv
